[hdl/csc_pkg.sv]
`timescale 1ns / 1ps

package csc_pkg;

   // datapath widths: coordinates with guard bits, angles in Q.30
   localparam int XY_W       = 42;
   localparam int Z_W        = 34;
   localparam int GUARD_BITS = 6;
   localparam int GAIN_LO_W  = 20;

   // request direction codes
   localparam logic ACT_TO_SPH  = 1'b0;
   localparam logic ACT_TO_RECT = 1'b1;

   // angle constants in Q.30 and Q.20
   localparam logic signed [Z_W-1:0] PI_Q30      = 34'sd3373259426;
   localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [Z_W-1:0] TWO_PI_Q30  = 34'sd6746518852;
   localparam logic signed [23:0]    PI_Q20      = 24'sd3294199;

   // CORDIC gain compensation
   localparam logic signed [XY_W-1:0] GAIN_Q30 = 42'sd652032874;
   localparam logic signed [24:0]     GAIN_Q24 = 25'sd10188014;

   // floor(2^50 / 2pi_q30): reciprocal for the angle reduction
   localparam logic [17:0] RECIP_K = 18'd166886;

   // atan(2^-i) in Q.30, truncated
   function automatic logic signed [Z_W-1:0] atan_q30(input int idx);
      logic signed [Z_W-1:0] v;
      case (idx)
         0:  v = 34'sh03243F6A8;
         1:  v = 34'sh01DAC6705;
         2:  v = 34'sh00FADBAFC;
         3:  v = 34'sh007F56EA6;
         4:  v = 34'sh003FEAB76;
         5:  v = 34'sh001FFD55B;
         6:  v = 34'sh000FFFAAA;
         7:  v = 34'sh0007FFF55;
         8:  v = 34'sh0003FFFEA;
         9:  v = 34'sh0001FFFFD;
         10: v = 34'sh0000FFFFF;
         11: v = 34'sh00007FFFF;
         12: v = 34'sh00003FFFF;
         13: v = 34'sh00001FFFF;
         14: v = 34'sh00000FFFF;
         15: v = 34'sh000007FFF;
         16: v = 34'sh000003FFF;
         17: v = 34'sh000001FFF;
         18: v = 34'sh000000FFF;
         19: v = 34'sh0000007FF;
         20: v = 34'sh0000003FF;
         21: v = 34'sh0000001FF;
         22: v = 34'sh0000000FF;
         23: v = 34'sh00000007F;
         24: v = 34'sh00000003F;
         25: v = 34'sh00000001F;
         26: v = 34'sh00000000F;
         27: v = 34'sh000000008;
         28: v = 34'sh000000004;
         29: v = 34'sh000000002;
         30: v = 34'sh000000001;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

[hdl/csc_reduce.sv]
`timescale 1ns / 1ps

module csc_reduce (
   input  logic                              clock,
   input  logic signed [31:0]                in_angle,
   output logic signed [csc_pkg::Z_W-1:0]    out_angle
);

   localparam int ZW = csc_pkg::Z_W;
   localparam logic [ZW-1:0] TWO_U = csc_pkg::TWO_PI_Q30;
   localparam logic [ZW-1:0] PI_U  = csc_pkg::PI_Q30;

   logic [31:0]            mag;
   logic [49:0]            qprod;
   logic [31:0]            mag1_ff;
   logic [9:0]             q1_ff;
   logic                   neg1_ff;
   logic [43:0]            num;
   logic [43:0]            sub;
   logic [43:0]            rem;
   logic [ZW-1:0]          rem2_ff;
   logic                   neg2_ff;
   logic [ZW-1:0]          rc;
   logic signed [ZW-1:0]   w_in;
   logic signed [ZW-1:0]   w3_ff;
   logic                   neg3_ff;

   // estimate the quotient by reciprocal multiplication
   assign mag   = in_angle[31] ? 32'(-in_angle) : 32'(in_angle);
   assign qprod = mag * csc_pkg::RECIP_K;

   always_ff @(posedge clock) begin
      mag1_ff <= mag;
      q1_ff   <= qprod[49:40];
      neg1_ff <= in_angle[31];
   end

   // remainder of |angle| * 1024, at most one period too large
   assign num = {2'b00, mag1_ff, 10'b0};
   assign sub = q1_ff * TWO_U;
   assign rem = num - sub;

   always_ff @(posedge clock) begin
      rem2_ff <= rem[ZW-1:0];
      neg2_ff <= neg1_ff;
   end

   // correct the estimate, then wrap above pi
   always_comb begin
      rc   = (rem2_ff >= TWO_U) ? rem2_ff - TWO_U : rem2_ff;
      w_in = (rc > PI_U) ? $signed(rc) - csc_pkg::TWO_PI_Q30 : $signed(rc);
   end

   always_ff @(posedge clock) begin
      w3_ff   <= w_in;
      neg3_ff <= neg2_ff;
   end

   // restore the sign of the request angle
   assign out_angle = neg3_ff ? -w3_ff : w3_ff;

endmodule

[hdl/csc_gain.sv]
`timescale 1ns / 1ps

module csc_gain (
   input  logic                              clock,
   input  logic signed [csc_pkg::XY_W-1:0]   in_data,
   output logic signed [csc_pkg::XY_W-1:0]   out_data
);

   localparam int XW   = csc_pkg::XY_W;
   localparam int LO_W = csc_pkg::GAIN_LO_W;
   localparam int HI_W = XW - LO_W;

   logic signed [LO_W+25:0]   lo_prod_ff;
   logic signed [HI_W+24:0]   hi_prod_ff;
   logic signed [XW+24:0]     sum;
   logic signed [XW-1:0]      out_ff;

   // split the operand into two partial products
   always_ff @(posedge clock) begin
      lo_prod_ff <= $signed({1'b0, in_data[LO_W-1:0]}) * csc_pkg::GAIN_Q24;
      hi_prod_ff <= $signed(in_data[XW-1:LO_W]) * csc_pkg::GAIN_Q24;
   end

   // combine and round from Q24
   assign sum = ((XW+25)'(hi_prod_ff) <<< LO_W) + (XW+25)'(lo_prod_ff)
                + (XW+25)'(25'sh0800000);

   always_ff @(posedge clock) begin
      out_ff <= sum[XW+23:24];
   end

   assign out_data = out_ff;

endmodule

[hdl/csc_cordic.sv]
`timescale 1ns / 1ps

module csc_cordic #(
   parameter int STEPS  = 24,
   parameter int SIDE_W = 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic                              in_vec,
   input  logic signed [csc_pkg::XY_W-1:0]   in_x,
   input  logic signed [csc_pkg::XY_W-1:0]   in_y,
   input  logic signed [csc_pkg::Z_W-1:0]    in_z,
   input  logic [SIDE_W-1:0]                 in_side,
   output logic                              out_valid,
   output logic signed [csc_pkg::XY_W-1:0]   out_x,
   output logic signed [csc_pkg::XY_W-1:0]   out_y,
   output logic signed [csc_pkg::Z_W-1:0]    out_z,
   output logic [SIDE_W-1:0]                 out_side
);

   localparam int XW = csc_pkg::XY_W;
   localparam int ZW = csc_pkg::Z_W;

   logic                   valid_ff [STEPS];
   logic                   vec_ff   [STEPS];
   logic signed [XW-1:0]   x_ff     [STEPS];
   logic signed [XW-1:0]   y_ff     [STEPS];
   logic signed [ZW-1:0]   z_ff     [STEPS];
   logic [SIDE_W-1:0]      side_ff  [STEPS];

   for (genvar i = 0; i < STEPS; i++) begin : g_stage
      logic                   pv;
      logic                   pvec;
      logic signed [XW-1:0]   px;
      logic signed [XW-1:0]   py;
      logic signed [ZW-1:0]   pz;
      logic [SIDE_W-1:0]      pside;
      logic signed [XW-1:0]   dx;
      logic signed [XW-1:0]   dy;
      logic signed [ZW-1:0]   angle;
      logic                   ccw;

      if (i == 0) begin : g_head
         assign pv    = in_valid;
         assign pvec  = in_vec;
         assign px    = in_x;
         assign py    = in_y;
         assign pz    = in_z;
         assign pside = in_side;
      end else begin : g_body
         assign pv    = valid_ff[i-1];
         assign pvec  = vec_ff[i-1];
         assign px    = x_ff[i-1];
         assign py    = y_ff[i-1];
         assign pz    = z_ff[i-1];
         assign pside = side_ff[i-1];
      end

      // pick the micro-rotation: drive y to zero or the angle to zero
      assign angle = csc_pkg::atan_q30(i);
      assign dx    = py >>> i;
      assign dy    = px >>> i;
      assign ccw   = pvec ? (py <= 0) : (pz >= 0);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else begin
            valid_ff[i] <= pv;
         end
         vec_ff[i]  <= pvec;
         side_ff[i] <= pside;
         if (ccw) begin
            x_ff[i] <= px - dx;
            y_ff[i] <= py + dy;
            z_ff[i] <= pz - angle;
         end else begin
            x_ff[i] <= px + dx;
            y_ff[i] <= py - dy;
            z_ff[i] <= pz + angle;
         end
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign out_x     = x_ff[STEPS-1];
   assign out_y     = y_ff[STEPS-1];
   assign out_z     = z_ff[STEPS-1];
   assign out_side  = side_ff[STEPS-1];

endmodule

[hdl/cartesian_spherical_converter.sv]
// A request flows through front, first CORDIC pass, middle, second pass, back end.
// Throughput: one request every cycle; busy stays low, the pipeline never stops.
// The two chained CORDIC pipelines, one stage per iteration, set the latency.
// Reset (synchronous, active high) clears the valid bits of every stage.
// Results come out for one cycle with rsp_strobe; the receiver cannot stall.
`timescale 1ns / 1ps

module cartesian_spherical_converter #(
   parameter int CORDIC_STEPS = 24
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_action,
   input  logic signed [31:0]  req_comp_first,
   input  logic signed [31:0]  req_comp_second,
   input  logic signed [31:0]  req_comp_third,
   output logic                rsp_strobe,
   output logic signed [31:0]  rsp_res_first,
   output logic signed [31:0]  rsp_res_second,
   output logic signed [31:0]  rsp_res_third,
   output logic                rsp_saturated
);

   localparam int XW = csc_pkg::XY_W;
   localparam int ZW = csc_pkg::Z_W;
   localparam int GB = csc_pkg::GUARD_BITS;
   localparam int RW = XW - GB;

   typedef struct packed {
      logic               action;
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic signed [31:0] c;
   } front_type;

   typedef struct packed {
      logic action;
      logic zero;
      logic flip;
   } side_a_type;

   typedef struct packed {
      logic               flip;
      logic signed [31:0] aux;
   } side_b_type;

   typedef struct packed {
      logic                 action;
      logic                 zero;
      logic signed [ZW-1:0] phi;
      logic signed [ZW-1:0] t;
      logic signed [31:0]   cp;
      logic signed [31:0]   sp;
      logic signed [ZW-1:0] zr;
   } side_c_type;

   typedef struct packed {
      logic                 flip;
      logic signed [ZW-1:0] ang;
   } fold_type;

   // fold an angle into [-pi/2, pi/2], flagging a half turn
   function automatic fold_type fold(input logic signed [ZW-1:0] ang);
      fold_type f;
      f.flip = 1'b0;
      f.ang  = ang;
      if (ang > csc_pkg::HALF_PI_Q30) begin
         f.ang  = ang - csc_pkg::PI_Q30;
         f.flip = 1'b1;
      end else if (ang < -csc_pkg::HALF_PI_Q30) begin
         f.ang  = ang + csc_pkg::PI_Q30;
         f.flip = 1'b1;
      end
      return f;
   endfunction

   // clip to the signed 32-bit range, flag in the top bit
   function automatic logic [32:0] sat36(input logic signed [RW-1:0] v);
      logic [32:0] r;
      r = {1'b0, v[31:0]};
      if (v > 36'sd2147483647) begin
         r = {1'b1, 32'h7FFFFFFF};
      end else if (v < -36'sd2147483648) begin
         r = {1'b1, 32'h80000000};
      end
      return r;
   endfunction

   // front: hold the request while the angles reduce
   front_type   front_ff [3];
   logic [2:0]  fvalid_ff;
   logic signed [ZW-1:0] phi_red;
   logic signed [ZW-1:0] theta_red;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         fvalid_ff <= '0;
      end else begin
         fvalid_ff <= {fvalid_ff[1:0], start & ~busy};
      end
      front_ff[0] <= {req_action, req_comp_first, req_comp_second, req_comp_third};
      front_ff[1] <= front_ff[0];
      front_ff[2] <= front_ff[1];
   end

   csc_reduce u_reduce_phi (
      .clock     (clock),
      .in_angle  (req_comp_second),
      .out_angle (phi_red)
   );

   csc_reduce u_reduce_theta (
      .clock     (clock),
      .in_angle  (req_comp_third),
      .out_angle (theta_red)
   );

   // prepare the first CORDIC pass
   front_type            fr;
   fold_type             fold_phi;
   fold_type             fold_theta;
   logic signed [XW-1:0] xg;
   logic signed [XW-1:0] yg;
   logic signed [XW-1:0] pa_x_in;
   logic signed [XW-1:0] pa_y_in;
   logic signed [ZW-1:0] pa_z_in;
   side_a_type           sa_in;
   side_b_type           sb_in;
   logic                 pv_ff;
   logic                 pa_vec_ff;
   logic signed [XW-1:0] pa_x_ff;
   logic signed [XW-1:0] pa_y_ff;
   logic signed [ZW-1:0] pa_z_ff;
   logic signed [ZW-1:0] pb_z_ff;
   side_a_type           sa_ff;
   side_b_type           sb_ff;

   assign fr         = front_ff[2];
   assign fold_phi   = fold(phi_red);
   assign fold_theta = fold(theta_red);

   always_comb begin
      xg = $signed({{(XW-32){fr.a[31]}}, fr.a}) <<< GB;
      yg = $signed({{(XW-32){fr.b[31]}}, fr.b}) <<< GB;
      pa_x_in      = csc_pkg::GAIN_Q30;
      pa_y_in      = '0;
      pa_z_in      = fold_phi.ang;
      sa_in.action = fr.action;
      sa_in.zero   = 1'b0;
      sa_in.flip   = fold_phi.flip;
      if (fr.action == csc_pkg::ACT_TO_SPH) begin
         sa_in.zero = (fr.a == 32'sd0) && (fr.b == 32'sd0);
         sa_in.flip = 1'b0;
         if (fr.a[31]) begin
            pa_x_in = -xg;
            pa_y_in = -yg;
            pa_z_in = fr.b[31] ? -csc_pkg::PI_Q30 : csc_pkg::PI_Q30;
         end else begin
            pa_x_in = xg;
            pa_y_in = yg;
            pa_z_in = '0;
         end
      end
      sb_in.flip = fold_theta.flip;
      sb_in.aux  = (fr.action == csc_pkg::ACT_TO_RECT) ? fr.a : fr.c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else begin
         pv_ff <= fvalid_ff[2];
      end
      pa_vec_ff <= (fr.action == csc_pkg::ACT_TO_SPH);
      pa_x_ff   <= pa_x_in;
      pa_y_ff   <= pa_y_in;
      pa_z_ff   <= pa_z_in;
      pb_z_ff   <= fold_theta.ang;
      sa_ff     <= sa_in;
      sb_ff     <= sb_in;
   end

   // first pass: planar vectoring or the two rotations
   logic                 a_valid;
   logic                 b_valid;
   logic signed [XW-1:0] ax;
   logic signed [XW-1:0] ay;
   logic signed [ZW-1:0] az;
   logic signed [XW-1:0] bx;
   logic signed [XW-1:0] by;
   side_a_type           a_side;
   side_b_type           b_side;

   csc_cordic #(
      .STEPS  (CORDIC_STEPS),
      .SIDE_W ($bits(side_a_type))
   ) u_cordic_a (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pv_ff),
      .in_vec    (pa_vec_ff),
      .in_x      (pa_x_ff),
      .in_y      (pa_y_ff),
      .in_z      (pa_z_ff),
      .in_side   (sa_ff),
      .out_valid (a_valid),
      .out_x     (ax),
      .out_y     (ay),
      .out_z     (az),
      .out_side  (a_side)
   );

   csc_cordic #(
      .STEPS  (CORDIC_STEPS),
      .SIDE_W ($bits(side_b_type))
   ) u_cordic_b (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pv_ff),
      .in_vec    (1'b0),
      .in_x      (csc_pkg::GAIN_Q30),
      .in_y      ({XW{1'b0}}),
      .in_z      (pb_z_ff),
      .in_side   (sb_ff),
      .out_valid (b_valid),
      .out_x     (bx),
      .out_y     (by),
      .out_z     (),
      .out_side  (b_side)
   );

   // middle: gain on rho, or r times sin and cos of theta
   logic signed [XW-1:0] rho;
   logic signed [ZW-1:0] phi_a;
   logic signed [31:0]   cp;
   logic signed [31:0]   sp;
   logic signed [31:0]   ct;
   logic signed [31:0]   st;
   logic signed [XW-1:0] rho_g;

   always_comb begin
      rho   = a_side.zero ? '0 : ax;
      phi_a = a_side.zero ? '0 : az;
      cp    = 32'(a_side.flip ? -ax : ax);
      sp    = 32'(a_side.flip ? -ay : ay);
      ct    = 32'(b_side.flip ? -bx : bx);
      st    = 32'(b_side.flip ? -by : by);
   end

   csc_gain u_gain_rho (
      .clock    (clock),
      .in_data  (rho),
      .out_data (rho_g)
   );

   logic                 m1_valid_ff;
   logic                 m1_action_ff;
   logic signed [63:0]   pst_ff;
   logic signed [63:0]   pct_ff;
   logic signed [ZW-1:0] phi1_ff;
   logic signed [31:0]   cp1_ff;
   logic signed [31:0]   sp1_ff;
   logic signed [31:0]   aux1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
      end else begin
         m1_valid_ff <= a_valid & b_valid;
      end
      m1_action_ff <= a_side.action;
      pst_ff       <= b_side.aux * st;
      pct_ff       <= b_side.aux * ct;
      phi1_ff      <= phi_a;
      cp1_ff       <= cp;
      sp1_ff       <= sp;
      aux1_ff      <= b_side.aux;
   end

   // round the products from Q30
   logic signed [63:0]   pst_rnd;
   logic signed [63:0]   pct_rnd;
   logic                 m2_valid_ff;
   logic                 m2_action_ff;
   logic signed [ZW-1:0] t2_ff;
   logic signed [ZW-1:0] zr2_ff;
   logic signed [ZW-1:0] phi2_ff;
   logic signed [31:0]   cp2_ff;
   logic signed [31:0]   sp2_ff;
   logic signed [31:0]   aux2_ff;

   assign pst_rnd = pst_ff + 64'sd536870912;
   assign pct_rnd = pct_ff + 64'sd536870912;

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_valid_ff <= 1'b0;
      end else begin
         m2_valid_ff <= m1_valid_ff;
      end
      m2_action_ff <= m1_action_ff;
      t2_ff        <= pst_rnd[63:30];
      zr2_ff       <= pct_rnd[63:30];
      phi2_ff      <= phi1_ff;
      cp2_ff       <= cp1_ff;
      sp2_ff       <= sp1_ff;
      aux2_ff      <= aux1_ff;
   end

   // prepare the second vectoring pass on (z, rho)
   logic signed [XW-1:0] zg;
   logic signed [XW-1:0] pc_x_in;
   logic signed [XW-1:0] pc_y_in;
   logic signed [ZW-1:0] pc_z_in;
   side_c_type           sc_in;
   logic                 pc_valid_ff;
   logic signed [XW-1:0] pc_x_ff;
   logic signed [XW-1:0] pc_y_ff;
   logic signed [ZW-1:0] pc_z_ff;
   side_c_type           sc_ff;

   always_comb begin
      zg = $signed({{(XW-32){aux2_ff[31]}}, aux2_ff}) <<< GB;
      if (aux2_ff[31]) begin
         pc_x_in = -zg;
         pc_y_in = -rho_g;
         pc_z_in = rho_g[XW-1] ? -csc_pkg::PI_Q30 : csc_pkg::PI_Q30;
      end else begin
         pc_x_in = zg;
         pc_y_in = rho_g;
         pc_z_in = '0;
      end
      sc_in.action = m2_action_ff;
      sc_in.zero   = (aux2_ff == 32'sd0) && (rho_g == '0);
      sc_in.phi    = phi2_ff;
      sc_in.t      = t2_ff;
      sc_in.cp     = cp2_ff;
      sc_in.sp     = sp2_ff;
      sc_in.zr     = zr2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_valid_ff <= 1'b0;
      end else begin
         pc_valid_ff <= m2_valid_ff;
      end
      pc_x_ff <= pc_x_in;
      pc_y_ff <= pc_y_in;
      pc_z_ff <= pc_z_in;
      sc_ff   <= sc_in;
   end

   // second pass: theta and the full length
   logic                 c_valid;
   logic signed [XW-1:0] cx;
   logic signed [ZW-1:0] cz;
   side_c_type           sc;

   csc_cordic #(
      .STEPS  (CORDIC_STEPS),
      .SIDE_W ($bits(side_c_type))
   ) u_cordic_c (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pc_valid_ff),
      .in_vec    (1'b1),
      .in_x      (pc_x_ff),
      .in_y      (pc_y_ff),
      .in_z      (pc_z_ff),
      .in_side   (sc_ff),
      .out_valid (c_valid),
      .out_x     (cx),
      .out_y     (),
      .out_z     (cz),
      .out_side  (sc)
   );

   // back end: gain on r, or t times cos and sin of phi
   logic signed [XW-1:0] mag;
   logic signed [ZW-1:0] theta_c;
   logic signed [XW-1:0] mag_g;

   assign mag     = sc.zero ? '0 : cx;
   assign theta_c = sc.zero ? '0 : cz;

   csc_gain u_gain_mag (
      .clock    (clock),
      .in_data  (mag),
      .out_data (mag_g)
   );

   logic                 f1_valid_ff;
   logic                 f1_action_ff;
   logic signed [65:0]   px_ff;
   logic signed [65:0]   py_ff;
   logic signed [ZW-1:0] zr1_ff;
   logic signed [ZW-1:0] phi3_ff;
   logic signed [ZW-1:0] theta1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= c_valid;
      end
      f1_action_ff <= sc.action;
      px_ff        <= sc.t * sc.cp;
      py_ff        <= sc.t * sc.sp;
      zr1_ff       <= sc.zr;
      phi3_ff      <= sc.phi;
      theta1_ff    <= theta_c;
   end

   logic signed [65:0]   px_rnd;
   logic signed [65:0]   py_rnd;
   logic                 f2_valid_ff;
   logic                 f2_action_ff;
   logic signed [RW-1:0] xr2_ff;
   logic signed [RW-1:0] yr2_ff;
   logic signed [ZW-1:0] zr3_ff;
   logic signed [ZW-1:0] phi4_ff;
   logic signed [ZW-1:0] theta2_ff;

   assign px_rnd = px_ff + 66'sd536870912;
   assign py_rnd = py_ff + 66'sd536870912;

   always_ff @(posedge clock) begin
      if (reset) begin
         f2_valid_ff <= 1'b0;
      end else begin
         f2_valid_ff <= f1_valid_ff;
      end
      f2_action_ff <= f1_action_ff;
      xr2_ff       <= px_rnd[65:30];
      yr2_ff       <= py_rnd[65:30];
      zr3_ff       <= zr1_ff;
      phi4_ff      <= phi3_ff;
      theta2_ff    <= theta1_ff;
   end

   // final rounding, clamping and saturation
   logic signed [XW-1:0] msum;
   logic signed [RW-1:0] mr;
   logic signed [ZW-1:0] phsum;
   logic signed [ZW-1:0] thsum;
   logic signed [23:0]   phr;
   logic signed [23:0]   thr;
   logic [32:0]          sat_r;
   logic [32:0]          sat_x;
   logic [32:0]          sat_y;
   logic [32:0]          sat_z;
   logic signed [31:0]   res_first_in;
   logic signed [31:0]   res_second_in;
   logic signed [31:0]   res_third_in;
   logic                 saturated_in;

   always_comb begin
      msum  = mag_g + 42'sd32;
      mr    = msum[XW-1:GB];
      if (mr < 0) begin
         mr = '0;
      end
      sat_r = sat36(mr);
      phsum = phi4_ff + 34'sd512;
      thsum = theta2_ff + 34'sd512;
      phr   = phsum[ZW-1:10];
      thr   = thsum[ZW-1:10];
      if (phr > csc_pkg::PI_Q20) begin
         phr = csc_pkg::PI_Q20;
      end else if (phr < -csc_pkg::PI_Q20) begin
         phr = -csc_pkg::PI_Q20;
      end
      if (thr > csc_pkg::PI_Q20) begin
         thr = csc_pkg::PI_Q20;
      end else if (thr < 0) begin
         thr = '0;
      end
      sat_x = sat36(xr2_ff);
      sat_y = sat36(yr2_ff);
      sat_z = sat36($signed({{(RW-ZW){zr3_ff[ZW-1]}}, zr3_ff}));
      if (f2_action_ff == csc_pkg::ACT_TO_SPH) begin
         res_first_in  = sat_r[31:0];
         res_second_in = 32'(phr);
         res_third_in  = 32'(thr);
         saturated_in  = sat_r[32];
      end else begin
         res_first_in  = sat_x[31:0];
         res_second_in = sat_y[31:0];
         res_third_in  = sat_z[31:0];
         saturated_in  = sat_x[32] | sat_y[32] | sat_z[32];
      end
   end

   logic                 strobe_ff;
   logic signed [31:0]   res_first_ff;
   logic signed [31:0]   res_second_ff;
   logic signed [31:0]   res_third_ff;
   logic                 saturated_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= f2_valid_ff;
      end
      res_first_ff  <= res_first_in;
      res_second_ff <= res_second_in;
      res_third_ff  <= res_third_in;
      saturated_ff  <= saturated_in;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_res_first  = res_first_ff;
   assign rsp_res_second = res_second_ff;
   assign rsp_res_third  = res_third_ff;
   assign rsp_saturated  = saturated_ff;

endmodule
